@@ rtl/fvc_pkg.sv @@
// ----------------------------------------------------------------------------
// fvc_pkg: shared types and constants for the forest vote classifier
// Operation codes, store geometry, controller states and command structs.
// ----------------------------------------------------------------------------
package fvc_pkg;

  localparam int NODE_DEPTH    = 4096;
  localparam int LEAF_BYTES    = 16384;
  localparam int MAX_TREES     = 64;
  localparam int MAX_CLASSES   = 16;
  localparam int FEATURE_COUNT = 256;
  localparam int MAX_DEPTH     = 64;

  localparam int NODE_AW = $clog2(NODE_DEPTH);
  localparam int LEAF_AW = $clog2(LEAF_BYTES);
  localparam int TREE_AW = $clog2(MAX_TREES);
  localparam int FEAT_AW = $clog2(FEATURE_COUNT);
  localparam int CLS_AW  = $clog2(MAX_CLASSES);
  localparam int STEP_W  = $clog2(MAX_DEPTH + 1);

  localparam int OP_W   = 3;
  localparam int ADDR_W = 14;
  localparam int PAY_W  = 56;
  localparam int VOTE_W = 14;
  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  localparam logic [OP_W-1:0] OP_LOAD_NODE = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_LEAF = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_ROOT = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_FEAT = 3'd3;
  localparam logic [OP_W-1:0] OP_CLASSIFY  = 3'd4;

  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_TREE_COUNT  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,     // waiting for a transaction
    ST_CLEAR,    // zero vote counters
    ST_ROOT,     // read root of current tree
    ST_NODE,     // node address ready, issue node read
    ST_DECODE,   // node word back, classify leaf or branch
    ST_FEAT,     // feature word back, take branch
    ST_LEAF,     // read leaf byte for current class
    ST_ADD,      // accumulate leaf byte
    ST_NEXT,     // advance to next tree
    ST_BEST,     // argmax scan
    ST_EMIT      // stream results
  } state_t;

  typedef struct packed {
    logic load_root;    // node pointer <- root data
    logic node_read;    // issue node store read
    logic feat_read;    // issue feature read
    logic take_branch;  // move pointer by compare result
    logic leaf_read;    // issue leaf byte read for class counter
    logic leaf_add;     // add leaf byte to vote of class counter
    logic leaf_base;    // latch leaf base address
    logic clear_votes;  // zero counters and fault
    logic set_fault;    // mark fault
    logic best_step;    // compare class counter with best
    logic best_init;    // best <- 0
  } dp_cmd_t;

  typedef struct packed {
    logic node_oob;     // pointer past node store
    logic is_leaf;      // right offset is zero
    logic feat_oob;     // feature index past store
    logic leaf_oob;     // leaf row past store
  } dp_stat_t;

  // IEEE single <= with NaN false and -0 == +0, on bit patterns
  function automatic logic goes_left(input logic [31:0] f, input logic [31:0] t);
    logic        fnan;
    logic        tnan;
    logic [31:0] fm;
    logic [31:0] tm;
    logic        le;
    fnan = f[30:0] > 31'h7F800000;
    tnan = t[30:0] > 31'h7F800000;
    fm   = {1'b0, f[30:0]};
    tm   = {1'b0, t[30:0]};
    priority if (fm == 32'd0 && tm == 32'd0) le = 1'b1;
    else if (!f[31] && !t[31]) le = fm <= tm;
    else if (f[31] && t[31])   le = fm >= tm;
    else le = f[31];
    return le && !fnan && !tnan;
  endfunction

endpackage

@@ rtl/fvc_datapath.sv @@
// ----------------------------------------------------------------------------
// fvc_datapath: stores, tree walker registers and vote counters
// Holds the four stores as memories and the per-class vote registers.
// ----------------------------------------------------------------------------
module fvc_datapath import fvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [PAY_W-1:0]  payload,
  input  dp_cmd_t           cmd,
  input  logic [TREE_AW-1:0] tree_sel,
  input  logic [CLS_AW-1:0] cls_sel,
  input  logic [CLS_AW:0]   classes,
  output dp_stat_t          stat,
  output logic [VOTE_W-1:0] vote_out,
  output logic [CLS_AW-1:0] best,
  output logic              fault
);

  logic [PAY_W-1:0]   node_mem [NODE_DEPTH];
  logic [7:0]         leaf_mem [LEAF_BYTES];
  logic [NODE_AW-1:0] root_mem [MAX_TREES];
  logic [31:0]        feat_mem [FEATURE_COUNT];

  logic [PAY_W-1:0]   node_q;
  logic [7:0]         leaf_q;
  logic [NODE_AW-1:0] root_q;
  logic [31:0]        feat_q;

  logic [16:0]        ptr;     // node pointer, wide to catch overrun
  logic [47:0]        lbase;   // leaf row base
  logic [VOTE_W-1:0]  votes [MAX_CLASSES];
  logic [VOTE_W:0]    sum;

  // store writes from load transactions
  always_ff @(posedge clk) begin
    if (in_take && operation == OP_LOAD_NODE && address < ADDR_W'(NODE_DEPTH))
      node_mem[address[NODE_AW-1:0]] <= payload;
    if (in_take && operation == OP_LOAD_LEAF && 32'(address) < LEAF_BYTES)
      leaf_mem[address[LEAF_AW-1:0]] <= payload[7:0];
    if (in_take && operation == OP_LOAD_ROOT && address < ADDR_W'(MAX_TREES))
      root_mem[address[TREE_AW-1:0]] <= payload[NODE_AW-1:0];
    if (in_take && operation == OP_LOAD_FEAT && address < ADDR_W'(FEATURE_COUNT))
      feat_mem[address[FEAT_AW-1:0]] <= payload[31:0];
  end

  // registered reads
  always_ff @(posedge clk) begin
    root_q <= root_mem[tree_sel];
    if (cmd.node_read) node_q <= node_mem[ptr[NODE_AW-1:0]];
    if (cmd.feat_read) feat_q <= feat_mem[node_q[FEAT_AW-1:0]];
    if (cmd.leaf_read) leaf_q <= leaf_mem[LEAF_AW'(lbase + 48'(cls_sel))];
  end

  // walker registers
  always_ff @(posedge clk) begin
    if (cmd.load_root) ptr <= 17'(root_q);
    else if (cmd.take_branch)
      ptr <= goes_left(feat_q, node_q[39:8]) ? ptr + 17'd1 : ptr + 17'(node_q[55:40]);
    if (cmd.leaf_base) lbase <= 48'(node_q[39:8]) * 48'(classes);
  end

  assign stat.node_oob = ptr >= 17'(NODE_DEPTH);
  assign stat.is_leaf  = node_q[55:40] == 16'd0;
  assign stat.feat_oob = 9'(node_q[7:0]) >= 9'(FEATURE_COUNT);
  assign stat.leaf_oob = lbase + 48'(classes) > 48'(LEAF_BYTES);

  assign sum      = {1'b0, votes[cls_sel]} + {7'd0, leaf_q};
  assign vote_out = votes[cls_sel];

  // vote counters, best and fault
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_votes) begin
      for (int i = 0; i < MAX_CLASSES; i++) votes[i] <= '0;
      fault <= 1'b0;
    end else begin
      if (cmd.leaf_add) votes[cls_sel] <= sum[VOTE_W] ? VOTE_MAX : sum[VOTE_W-1:0];
      if (cmd.set_fault) fault <= 1'b1;
    end
    if (cmd.best_init) best <= '0;
    else if (cmd.best_step && votes[cls_sel] > votes[best]) best <= cls_sel;
  end

endmodule

@@ rtl/fvc_control.sv @@
// ----------------------------------------------------------------------------
// fvc_control: sequencer for the forest walk and result stream
// Steps trees, nodes and classes and raises result valid while streaming.
// ----------------------------------------------------------------------------
module fvc_control import fvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [OP_W-1:0]   operation,
  input  logic [CLS_AW:0]   classes,
  input  logic [TREE_AW:0]  trees,
  input  dp_stat_t          stat,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              in_take,
  output dp_cmd_t           cmd,
  output logic [TREE_AW-1:0] tree_sel,
  output logic [CLS_AW-1:0] cls_sel,
  output logic              out_valid,
  output logic              out_last
);

  state_t            state, state_next;
  logic [TREE_AW:0]  tree, tree_next;
  logic [CLS_AW:0]   cls, cls_next;
  logic [STEP_W-1:0] steps, steps_next;

  assign in_stall = state != ST_IDLE;
  assign in_take  = in_valid && !in_stall;
  // root read is registered, so its address is taken from the next value of the tree counter
  assign tree_sel = tree_next[TREE_AW-1:0];
  assign cls_sel  = cls[CLS_AW-1:0];
  assign out_last = cls + 1'b1 == classes;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tree  <= '0;
      cls   <= '0;
      steps <= '0;
    end else begin
      state <= state_next;
      tree  <= tree_next;
      cls   <= cls_next;
      steps <= steps_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    tree_next  = tree;
    cls_next   = cls;
    steps_next = steps;
    cmd        = '0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tree_next = '0;
        if (in_take && operation == OP_CLASSIFY) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear_votes = 1'b1;
        state_next = trees == '0 ? ST_BEST : ST_ROOT;
        cls_next   = '0;
      end
      ST_ROOT: begin
        cmd.load_root = 1'b1;
        steps_next = '0;
        state_next = ST_NODE;
      end
      ST_NODE: begin
        if (stat.node_oob) begin
          cmd.set_fault = 1'b1;
          state_next = ST_NEXT;
        end else begin
          cmd.node_read = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_leaf) begin
          cmd.leaf_base = 1'b1;
          cls_next   = '0;
          state_next = ST_LEAF;
        end else if (steps >= STEP_W'(MAX_DEPTH) || stat.feat_oob) begin
          cmd.set_fault = 1'b1;
          state_next = ST_NEXT;
        end else begin
          cmd.feat_read = 1'b1;
          steps_next = steps + 1'b1;
          state_next = ST_FEAT;
        end
      end
      ST_FEAT: begin
        cmd.take_branch = 1'b1;
        state_next = ST_NODE;
      end
      ST_LEAF: begin
        if (stat.leaf_oob) begin
          cmd.set_fault = 1'b1;
          state_next = ST_NEXT;
        end else begin
          cmd.leaf_read = 1'b1;
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.leaf_add = 1'b1;
        cls_next = cls + 1'b1;
        state_next = cls + 1'b1 == classes ? ST_NEXT : ST_LEAF;
      end
      ST_NEXT: begin
        tree_next = tree + 1'b1;
        cls_next  = '0;
        state_next = tree + 1'b1 == trees ? ST_BEST : ST_ROOT;
      end
      ST_BEST: begin
        if (cls == '0) cmd.best_init = 1'b1;
        else cmd.best_step = 1'b1;
        cls_next = cls + 1'b1;
        if (cls + 1'b1 == classes) begin
          cls_next   = '0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cls_next = cls + 1'b1;
          if (out_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/forest_vote_classifier_top.sv @@
// ----------------------------------------------------------------------------
// forest_vote_classifier_top: decision forest inference with class votes
// Load transactions fill node, leaf, root and feature stores; classify walks.
// ----------------------------------------------------------------------------
// Load transactions are taken back to back while the sequencer is idle. A classify
// clears the votes, then per tree reads the root, walks the branch nodes and adds
// the leaf row class by class (a fault ends that tree early), then scans the
// classes for the argmax, then streams one result per class, one per unstalled cycle.
// The pace is set by the single read port of each store that the walk
// sequencer visits in turn. No item is accepted until the last result of a
// classify has been taken.
module forest_vote_classifier_top import fvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [PAY_W-1:0]  payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        class_index,
  output logic [VOTE_W-1:0] vote_total,
  output logic [3:0]        best_class,
  output logic              fault,
  output logic              last
);

  logic [4:0]         class_count;
  logic [6:0]         tree_count;
  logic [CLS_AW:0]    classes;
  logic [TREE_AW:0]   trees;
  logic               in_take;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [TREE_AW-1:0] tree_sel;
  logic [CLS_AW-1:0]  cls_sel;
  logic [CLS_AW-1:0]  best;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= 5'd2;
      tree_count  <= 7'd1;
    end else if (cfg_write) begin
      if (cfg_index == REG_CLASS_COUNT) class_count <= cfg_data[4:0];
      if (cfg_index == REG_TREE_COUNT)  tree_count  <= cfg_data;
    end
  end

  // clamp counts
  always_comb begin
    priority if (class_count == 5'd0) classes = (CLS_AW+1)'(1);
    else if (32'(class_count) > MAX_CLASSES) classes = (CLS_AW+1)'(MAX_CLASSES);
    else classes = (CLS_AW+1)'(class_count);
    if (32'(tree_count) > MAX_TREES) trees = (TREE_AW+1)'(MAX_TREES);
    else trees = (TREE_AW+1)'(tree_count);
  end

  fvc_control u_ctl (
    .clk, .rst, .in_valid, .operation, .classes, .trees, .stat, .out_stall,
    .in_stall, .in_take, .cmd, .tree_sel, .cls_sel, .out_valid, .out_last(last)
  );

  fvc_datapath u_dp (
    .clk, .rst, .in_take, .operation, .address, .payload, .cmd, .tree_sel,
    .cls_sel, .classes, .stat, .vote_out(vote_total), .best, .fault
  );

  assign class_index = 4'(cls_sel);
  assign best_class  = 4'(best);

  // results only while busy, class index in range, and a result held under stall
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during result stream");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (5'(class_index) < 5'(classes))) else $error("class index past count");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(class_index))
    else $error("result dropped under stall");

endmodule

@@ tb/forest_vote_classifier_top_test.sv @@
// ----------------------------------------------------------------------------
// forest_vote_classifier_top_test: self-checking bench for the forest classifier
// Loads small forests through the item port, classifies, and checks every class
// result against a bit-accurate tally of the loaded forest kept in the bench.
// ----------------------------------------------------------------------------
module forest_vote_classifier_top_test;
  import fvc_pkg::*;

  localparam int LIMIT = 3000000;
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int NO_FAULT_CHECK = 2;

  typedef enum int {GAP_NONE, GAP_ROOT, GAP_NODE, GAP_LEAF, GAP_FEAT} gap_t;

  typedef struct {
    logic [3:0]        cls;
    logic [VOTE_W-1:0] votes;
    logic [3:0]        best;
    logic              flt;
    logic              fin;
  } class_result_t;

  typedef struct {
    bit                is_cfg;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [PAY_W-1:0]  pay;
    int                want_fault;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [6:0]        cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [PAY_W-1:0]  payload;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        class_index;
  logic [VOTE_W-1:0] vote_total;
  logic [3:0]        best_class;
  logic              fault;
  logic              last;

  forest_vote_classifier_top i_dut (.*);

  // bench copy of the forest and the registers
  bit [PAY_W-1:0] node_mem [NODE_DEPTH];
  bit             node_set [NODE_DEPTH];
  bit [7:0]       leaf_mem [LEAF_BYTES];
  bit             leaf_set [LEAF_BYTES];
  bit [11:0]      root_mem [MAX_TREES];
  bit             root_set [MAX_TREES];
  bit [31:0]      feat_mem [FEATURE_COUNT];
  bit             feat_set [FEATURE_COUNT];
  bit [4:0]       class_reg = 5'd2;
  bit [6:0]       tree_reg  = 7'd1;

  class_result_t expected_votes[$];
  int  errors = 0;
  int  cycles = 0;
  int  random_items = 0;
  bit  quiet = 0;
  bit  long_hold = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // IEEE single <= on bit patterns: NaN never passes, signed zeros are equal
  function automatic bit float_le(bit [31:0] a, bit [31:0] b);
    longint ka;
    longint kb;
    if (a[30:0] > 31'h7F800000 || b[30:0] > 31'h7F800000) return 0;
    ka = a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
    kb = b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
    return ka <= kb;
  endfunction

  // Walks every active tree and reports the first store entry it would read
  // unwritten; with emit set and no such entry, it queues the class results.
  function automatic gap_t tally_forest(input bit emit, output int gap_addr);
    int         classes;
    int         trees;
    bit [13:0]  votes [16];
    bit         hit_fault;
    longint     node;
    longint     base;
    int         steps;
    int         best;
    bit         done;
    bit [PAY_W-1:0] w;
    bit [15:0]  right;
    bit [31:0]  field;
    bit [7:0]   fi;
    bit [14:0]  sum;
    class_result_t r;
    gap_addr = 0;
    hit_fault = 0;
    classes = (class_reg == 0) ? 1 : int'(class_reg);
    if (classes > MAX_CLASSES) classes = MAX_CLASSES;
    trees = (tree_reg > MAX_TREES) ? MAX_TREES : int'(tree_reg);
    foreach (votes[c]) votes[c] = '0;
    for (int t = 0; t < trees; t++) begin
      if (!root_set[t]) begin
        gap_addr = t;
        return GAP_ROOT;
      end
      node = root_mem[t];
      steps = 0;
      done = 0;
      while (!done) begin
        if (node >= NODE_DEPTH) begin
          hit_fault = 1;
          done = 1;
        end else begin
          if (!node_set[node]) begin
            gap_addr = int'(node);
            return GAP_NODE;
          end
          w = node_mem[node];
          right = w[55:40];
          field = w[39:8];
          if (right == 0) begin
            base = longint'(field) * classes;
            if (base + classes > LEAF_BYTES) hit_fault = 1;
            else begin
              for (int c = 0; c < classes; c++) begin
                if (!leaf_set[base + c]) begin
                  gap_addr = int'(base + c);
                  return GAP_LEAF;
                end
                sum = votes[c] + leaf_mem[base + c];
                votes[c] = (sum > 15'd16383) ? 14'd16383 : sum[13:0];
              end
            end
            done = 1;
          end else if (steps >= MAX_DEPTH) begin
            hit_fault = 1;
            done = 1;
          end else begin
            steps++;
            fi = w[7:0];
            if (!feat_set[fi]) begin
              gap_addr = fi;
              return GAP_FEAT;
            end
            node = float_le(feat_mem[fi], field) ? node + 1 : node + right;
          end
        end
      end
    end
    if (emit) begin
      best = 0;
      for (int c = 1; c < classes; c++)
        if (votes[c] > votes[best]) best = c;
      for (int c = 0; c < classes; c++) begin
        r.cls   = c[3:0];
        r.votes = votes[c];
        r.best  = best[3:0];
        r.flt   = hit_fault;
        r.fin   = (c + 1 == classes);
        expected_votes.push_back(r);
      end
    end
    return GAP_NONE;
  endfunction

  // update the bench copy for one accepted transaction
  function automatic void absorb_item(logic [2:0] op, logic [13:0] addr, logic [55:0] pay);
    int unused;
    gap_t g;
    case (op)
      OP_LOAD_NODE: if (addr < NODE_DEPTH) begin
        node_mem[addr] = pay;
        node_set[addr] = 1;
      end
      OP_LOAD_LEAF: begin
        leaf_mem[addr] = pay[7:0];
        leaf_set[addr] = 1;
      end
      OP_LOAD_ROOT: if (addr < MAX_TREES) begin
        root_mem[addr] = pay[11:0];
        root_set[addr] = 1;
      end
      OP_LOAD_FEAT: if (addr < FEATURE_COUNT) begin
        feat_mem[addr] = pay[31:0];
        feat_set[addr] = 1;
      end
      OP_CLASSIFY: g = tally_forest(1, unused);
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [2:0] op, logic [13:0] addr, logic [55:0] pay);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1;
    operation <= op;
    address   <= addr;
    payload   <= pay;
    do @(posedge clk); while (in_stall);
    absorb_item(op, addr, pay);
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'h80000000;
      2: return 32'h7F800000;
      3: return 32'hFF800000;
      4: return 32'h7F800000 | $urandom_range(1, 32'h7FFFFF) | ($urandom_range(0, 1) << 31);
      5: return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 130)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // fill whatever the next walk would read unwritten, then classify
  task automatic classify_filled();
    int   a;
    gap_t g;
    g = tally_forest(0, a);
    while (g != GAP_NONE) begin
      case (g)
        GAP_ROOT: send_item(OP_LOAD_ROOT, a[13:0], 56'($urandom_range(0, 63)));
        GAP_NODE: send_item(OP_LOAD_NODE, a[13:0],
                            {16'd0, 32'($urandom_range(0, 7)), 8'($urandom)});
        GAP_LEAF: send_item(OP_LOAD_LEAF, a[13:0], 56'($urandom));
        default:  send_item(OP_LOAD_FEAT, a[13:0], 56'(pick_float()));
      endcase
      g = tally_forest(0, a);
    end
    send_item(OP_CLASSIFY, 14'($urandom), {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_CLASS_COUNT) class_reg = val[4:0];
    else if (idx == REG_TREE_COUNT) tree_reg = val;
    cfg_write <= 0;
  endtask

  // one random node: mostly short branches, some leaves
  function automatic logic [55:0] pick_node();
    if ($urandom_range(0, 9) < 4)
      return {16'd0, 32'($urandom_range(0, 15)), 8'($urandom)};
    return {16'($urandom_range(1, 4)), pick_float(), 8'($urandom_range(0, 15))};
  endfunction

  task automatic random_sequence();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      // noise: any code, any address
      logic [2:0] op;
      op = 3'($urandom);
      if (op == OP_CLASSIFY) classify_filled();
      else send_item(op, 14'($urandom), {$urandom, $urandom});
      random_items++;
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_LOAD_ROOT, 14'($urandom_range(0, 7)), 56'($urandom_range(0, 63)));
          1: send_item(OP_LOAD_NODE, 14'($urandom_range(0, 63)), pick_node());
          2: send_item(OP_LOAD_LEAF, 14'($urandom_range(0, 255)), 56'($urandom));
          default: send_item(OP_LOAD_FEAT, 14'($urandom_range(0, 15)), 56'(pick_float()));
        endcase
      end
      classify_filled();
      random_items += n + 1;
    end
  endtask

  // directed rows: fault typed in where it is obvious, votes from the tally
  stim_row_t directed_rows[30] = '{
    '{0, OP_LOAD_ROOT, 14'd0,     56'd10,                          NO_FAULT_CHECK},
    '{0, OP_LOAD_NODE, 14'd10,    {16'd2, 32'h00000000, 8'd0},     NO_FAULT_CHECK},
    '{0, OP_LOAD_NODE, 14'd11,    {16'd0, 32'd0, 8'd0},            NO_FAULT_CHECK},
    '{0, OP_LOAD_NODE, 14'd12,    {16'd0, 32'd1, 8'd0},            NO_FAULT_CHECK},
    '{0, OP_LOAD_LEAF, 14'd0,     56'd0,                           NO_FAULT_CHECK},
    '{0, OP_LOAD_LEAF, 14'd1,     56'd255,                         NO_FAULT_CHECK},
    '{0, OP_LOAD_LEAF, 14'd2,     56'd7,                           NO_FAULT_CHECK},
    '{0, OP_LOAD_LEAF, 14'd3,     56'd7,                           NO_FAULT_CHECK},
    // negative zero equals the positive zero threshold
    '{0, OP_LOAD_FEAT, 14'd0,     56'h80000000,                    NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd0,     56'd0,                           0},
    // NaN feature goes right, tied votes pick class 0
    '{0, OP_LOAD_FEAT, 14'd0,     56'h7FC00000,                    NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd0,     56'd0,                           0},
    '{0, OP_LOAD_FEAT, 14'd0,     56'hFF800000,                    NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd16383, '1,                              0},
    // NaN threshold goes right
    '{0, OP_LOAD_NODE, 14'd10,    {16'd2, 32'h7FC00001, 8'd0},     NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd0,     56'd0,                           0},
    // out-of-range loads and spare codes are dropped, then the top leaf byte is loaded
    '{0, OP_LOAD_NODE, 14'd4096,  '1,                              NO_FAULT_CHECK},
    '{0, OP_LOAD_ROOT, 14'd64,    56'd5,                           NO_FAULT_CHECK},
    '{0, OP_LOAD_FEAT, 14'd16383, '1,                              NO_FAULT_CHECK},
    '{0, OP_SPARE_5,   14'd0,     56'd0,                           NO_FAULT_CHECK},
    '{0, OP_SPARE_7,   14'd16383, '1,                              NO_FAULT_CHECK},
    '{0, OP_LOAD_LEAF, 14'd16383, 56'hAA,                          NO_FAULT_CHECK},
    // second tree branches past the node store
    '{0, OP_LOAD_ROOT, 14'd1,     56'd4095,                        NO_FAULT_CHECK},
    '{0, OP_LOAD_NODE, 14'd4095,  '1,                              NO_FAULT_CHECK},
    '{0, OP_LOAD_FEAT, 14'd255,   '1,                              NO_FAULT_CHECK},
    '{1, OP_LOAD_NODE, 14'(REG_TREE_COUNT), 56'd2,                 NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd0,     56'd0,                           1},
    // leaf row past the leaf store
    '{0, OP_LOAD_NODE, 14'd12,    {16'd0, 32'hFFFFFFFF, 8'd0},     NO_FAULT_CHECK},
    '{1, OP_LOAD_NODE, 14'(REG_TREE_COUNT), 56'd1,                 NO_FAULT_CHECK},
    '{0, OP_CLASSIFY,  14'd0,     56'd0,                           1}
  };

  // register settings per phase: class count data, tree count data
  logic [6:0] phase_classes[10] = '{7'd2, 7'd2, 7'd16, 7'd1, 7'd0, 7'h7F, 7'd16, 7'd5, 7'd3, 7'd8};
  logic [6:0] phase_trees[10]   = '{7'd1, 7'd2, 7'd4,  7'd3, 7'd2, 7'd5,  7'd6, 7'd127, 7'd0, 7'd8};

  // receiver stall: random bursts, one long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        long_hold = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic note_mismatch(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endtask

  // result checker
  always @(posedge clk) begin
    class_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_votes.size() == 0)
        note_mismatch($sformatf("unexpected result class %0d total %0d",
                                class_index, vote_total));
      else begin
        e = expected_votes.pop_front();
        if (class_index !== e.cls || vote_total !== e.votes || best_class !== e.best ||
            fault !== e.flt || last !== e.fin)
          note_mismatch($sformatf(
            "exp cls %0d votes %0d best %0d fault %0d last %0d, got %0d %0d %0d %0d %0d",
            e.cls, e.votes, e.best, e.flt, e.fin,
            class_index, vote_total, best_class, fault, last));
      end
    end
  end

  initial begin
    int target;
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 0;
    operation = '0;
    address   = '0;
    payload   = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        write_reg(directed_rows[i].addr[1:0], directed_rows[i].pay[6:0]);
      end else if (directed_rows[i].op == OP_CLASSIFY) begin
        classify_filled();
        if (directed_rows[i].want_fault != NO_FAULT_CHECK)
          foreach (expected_votes[k]) expected_votes[k].flt = directed_rows[i].want_fault[0];
      end else
        send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].pay);
    end

    // walk one branch deeper than allowed on the third tree
    wait_drained();
    write_reg(REG_TREE_COUNT, 7'd3);
    send_item(OP_LOAD_FEAT, 14'd0, 56'h3F800000);
    send_item(OP_LOAD_ROOT, 14'd2, 56'd2000);
    for (int n = 0; n <= MAX_DEPTH; n++)
      send_item(OP_LOAD_NODE, 14'(2000 + n), {16'd1000, 32'h7F800000, 8'd0});
    send_item(OP_LOAD_NODE, 14'(2001 + MAX_DEPTH), {16'd0, 32'd0, 8'd0});
    classify_filled();
    foreach (expected_votes[k]) expected_votes[k].flt = 1'b1;

    // random phases over register settings
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_reg(REG_CLASS_COUNT, phase_classes[p]);
      write_reg(REG_TREE_COUNT, phase_trees[p]);
      if (p == 2) long_hold = 1;
      if (p == 9) quiet = 1;
      target = random_items + 3;
      while (random_items < target) random_sequence();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (expected_votes.size() != 0) errors++;
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
